>>> rtl/stack_sort_reverse_engine_core_macros.svh
// assertion macros used by the stack engine checker
`ifndef STACK_SORT_REVERSE_ENGINE_CORE_MACROS_SVH
`define STACK_SORT_REVERSE_ENGINE_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SSRE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stack engine check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SSRE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stack engine check failed");

`endif

>>> rtl/ssre_pkg.sv
// types, codes and constants of the stack sort/reverse engine
package ssre_pkg;

    localparam int SSRE_DEPTH = 16;
    localparam int WORD_W     = 32;
    localparam int CMD_W      = 3;
    localparam int STATUS_W   = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PRINT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SORT    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_ACK  = 13'b0000000000010,
        S_PRD  = 13'b0000000000100,
        S_POUT = 13'b0000000001000,
        S_SRA  = 13'b0000000010000,
        S_SLA  = 13'b0000000100000,
        S_SRB  = 13'b0000001000000,
        S_SCMP = 13'b0000010000000,
        S_SWB  = 13'b0000100000000,
        S_RLO  = 13'b0001000000000,
        S_RHI  = 13'b0010000000000,
        S_RW1  = 13'b0100000000000,
        S_RW2  = 13'b1000000000000
    } state_t;

endpackage

>>> rtl/stack_sort_reverse_engine_core.sv
// top level of the bounded stack engine with push, pop, print, sort and reverse
//
//   channel | dir | tdata            | tuser                        | tlast
//   s_*     | in  | item [31:0]      | command [2:0]                | -
//   m_*     | out | value [31:0]     | has_value [0], status [2:1]  | last
//
// one command is in work at a time; s_tready is high only when the sequencer idles
// push and pop acknowledge from S_ACK, print sends one entry at a time, reverse swaps pairs
// sort runs its passes over all n entries before its acknowledgement:
// one ram read port, one compare per step
// a result waits in the output register while the next word is taken in
// reset clears the entry count; the entry ram needs no clearing
module stack_sort_reverse_engine_core #(
    parameter int DEPTH = ssre_pkg::SSRE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ssre_pkg::WORD_W-1:0]  s_tdata,   // item
    input  logic [ssre_pkg::CMD_W-1:0]   s_tuser,   // command
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ssre_pkg::WORD_W-1:0]  m_tdata,   // value
    output logic [ssre_pkg::STATUS_W:0]  m_tuser,   // has_value, status
    output logic                         m_tlast
);

    import ssre_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       pi_reg, pi_next;
    logic [AW-1:0]       pj_reg, pj_next;
    logic [WORD_W-1:0]   a_reg, a_next;
    logic [STATUS_W-1:0] st_reg, st_next;

    logic                m_tvalid_reg;
    logic [WORD_W-1:0]   value_reg;
    logic                has_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                last_reg;

    logic                load_out;
    logic [WORD_W-1:0]   ld_value;
    logic                ld_has;
    logic [STATUS_W-1:0] ld_status;
    logic                ld_last;

    logic                we, re;
    logic [AW-1:0]       waddr, raddr;
    logic [WORD_W-1:0]   wdata, rdata;

    logic                accept, out_free;
    logic [AW-1:0]       top_idx;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign top_idx  = count_reg[AW-1:0] - AW'(1);

    ssre_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pi_next    = pi_reg;
        pj_next    = pj_reg;
        a_next     = a_reg;
        st_next    = st_reg;
        we         = 1'b0;
        waddr      = '0;
        wdata      = '0;
        re         = 1'b0;
        raddr      = '0;
        load_out   = 1'b0;
        ld_value   = '0;
        ld_has     = 1'b0;
        ld_status  = ST_OK;
        ld_last    = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    st_next = ST_OK;
                    unique case (s_tuser)
                        CMD_PUSH:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                waddr      = count_reg[AW-1:0];
                                wdata      = s_tdata;
                                count_next = count_reg + CW'(1);
                            end
                            state_next = S_ACK;
                        end
                        CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                            state_next = S_ACK;
                        end
                        CMD_PRINT:
                        begin
                            if (count_reg == '0)
                            begin
                                state_next = S_ACK;
                            end
                            else
                            begin
                                pi_next    = top_idx;
                                state_next = S_PRD;
                            end
                        end
                        CMD_SORT:
                        begin
                            if (count_reg == '0)
                            begin
                                state_next = S_ACK;
                            end
                            else
                            begin
                                pi_next    = top_idx;
                                state_next = S_SRA;
                            end
                        end
                        CMD_REVERSE:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                state_next = S_ACK;
                            end
                            else
                            begin
                                pi_next    = '0;
                                pj_next    = top_idx;
                                state_next = S_RLO;
                            end
                        end
                        default:
                        begin
                            // unused codes are dropped without a result
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ACK:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    ld_status  = st_reg;
                    state_next = S_IDLE;
                end
            end
            S_PRD:
            begin
                re         = 1'b1;
                raddr      = pi_reg;
                state_next = S_POUT;
            end
            S_POUT:
            begin
                // read data holds while the output register is busy
                if (out_free)
                begin
                    load_out = 1'b1;
                    ld_value = rdata;
                    ld_has   = 1'b1;
                    ld_last  = (pi_reg == '0);
                    if (pi_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pi_next    = pi_reg - AW'(1);
                        state_next = S_PRD;
                    end
                end
            end
            S_SRA:
            begin
                re         = 1'b1;
                raddr      = pi_reg;
                pj_next    = top_idx;
                state_next = S_SLA;
            end
            S_SLA:
            begin
                a_next     = rdata;
                state_next = S_SRB;
            end
            S_SRB:
            begin
                // comparing an entry with itself never swaps
                if (pj_reg == pi_reg)
                begin
                    if (pj_reg == '0)
                    begin
                        state_next = S_SWB;
                    end
                    else
                    begin
                        pj_next = pj_reg - AW'(1);
                    end
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = pj_reg;
                    state_next = S_SCMP;
                end
            end
            S_SCMP:
            begin
                // the i-side entry lives in a_reg until the inner pass ends
                if ($signed(rdata) > $signed(a_reg))
                begin
                    we     = 1'b1;
                    waddr  = pj_reg;
                    wdata  = a_reg;
                    a_next = rdata;
                end
                if (pj_reg == '0)
                begin
                    state_next = S_SWB;
                end
                else
                begin
                    pj_next    = pj_reg - AW'(1);
                    state_next = S_SRB;
                end
            end
            S_SWB:
            begin
                we    = 1'b1;
                waddr = pi_reg;
                wdata = a_reg;
                if (pi_reg == '0)
                begin
                    state_next = S_ACK;
                end
                else
                begin
                    pi_next    = pi_reg - AW'(1);
                    state_next = S_SRA;
                end
            end
            S_RLO:
            begin
                re         = 1'b1;
                raddr      = pi_reg;
                state_next = S_RHI;
            end
            S_RHI:
            begin
                a_next     = rdata;
                re         = 1'b1;
                raddr      = pj_reg;
                state_next = S_RW1;
            end
            S_RW1:
            begin
                we         = 1'b1;
                waddr      = pi_reg;
                wdata      = rdata;
                state_next = S_RW2;
            end
            S_RW2:
            begin
                we    = 1'b1;
                waddr = pj_reg;
                wdata = a_reg;
                if ((pi_reg + AW'(1)) < (pj_reg - AW'(1)))
                begin
                    pi_next    = pi_reg + AW'(1);
                    pj_next    = pj_reg - AW'(1);
                    state_next = S_RLO;
                end
                else
                begin
                    state_next = S_ACK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pi_reg <= pi_next;
        pj_reg <= pj_next;
        a_reg  <= a_next;
        st_reg <= st_next;
        if (load_out)
        begin
            value_reg  <= ld_value;
            has_reg    <= ld_has;
            status_reg <= ld_status;
            last_reg   <= ld_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = value_reg;
    assign m_tuser  = {status_reg, has_reg};
    assign m_tlast  = last_reg;

endmodule

>>> rtl/ssre_ram.sv
// generic single-write, single-read ram with registered read data
module ssre_ram #(
    parameter int WIDTH = ssre_pkg::WORD_W,
    parameter int DEPTH = ssre_pkg::SSRE_DEPTH
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/ssre_checker.sv
// port-level checks of the stack engine and their bind to the top level
`include "stack_sort_reverse_engine_core_macros.svh"

module ssre_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [ssre_pkg::CMD_W-1:0]   s_tuser,   // command
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [ssre_pkg::WORD_W-1:0]  m_tdata,   // value
    input logic [ssre_pkg::STATUS_W:0]  m_tuser,   // has_value, status
    input logic                         m_tlast
);

    import ssre_pkg::*;

    logic cmd_known;
    logic in_word;

    assign cmd_known = (s_tuser <= CMD_REVERSE);
    assign in_word   = s_tvalid && s_tready;

    // a stalled result word holds
    `SSRE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // acknowledgements are single-word runs with zero data
    `SSRE_ASSERT_SAME(a_ack_shape, m_tvalid && !m_tuser[0], m_tlast && (m_tdata == '0))

    // entry words from print always carry an ok status
    `SSRE_ASSERT_SAME(a_entry_ok, m_tvalid && m_tuser[0], m_tuser[STATUS_W:1] == ST_OK)

    // every known command takes the engine out of idle in the cycle after it is taken
    `SSRE_ASSERT_NEXT(a_busy_after_cmd, in_word && cmd_known, !s_tready)

endmodule

bind stack_sort_reverse_engine_core ssre_checker u_ssre_checker (.*);
